[sv/qvr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and types for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int InW   = 16;
    localparam int OutW  = 17;
    localparam int ProdW = 32;
    localparam int NormW = 33;
    localparam int NumW  = 52;
    localparam int DivW  = 34;
    localparam int QuoW  = 17;

    typedef logic signed [InW-1:0]   in_t;
    typedef logic signed [OutW-1:0]  out_t;
    typedef logic signed [ProdW-1:0] prod_t;
    typedef logic signed [NumW-1:0]  num_t;
    typedef logic [NumW-1:0]         rem_t;
    typedef logic [DivW-1:0]         dvs_t;
    typedef logic [QuoW-1:0]         quo_t;

endpackage

[sv/quaternion_vector_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a vector by a quaternion of any scale, rounded and saturated.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one quaternion and one vector per beat on
// in_valid and in_stall. The output channel carries the rotated vector and
// the zero quaternion flag per beat on out_valid and out_stall.
// The block takes one beat in every cycle while the output is not held.
// Four stages form the products, the norm and the rotated numerators, and
// seventeen stages each produce one quotient bit of a restoring divide per
// component; the last stage applies the sign and saturates.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises, so no beat is lost or repeated.
// Reset clears all valid bits; the data path needs no reset.
// A zero quaternion gives a zero vector with zero_quat set.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  qvr_pkg::in_t    quat_x,
    input  qvr_pkg::in_t    quat_y,
    input  qvr_pkg::in_t    quat_z,
    input  qvr_pkg::in_t    quat_w,
    input  qvr_pkg::in_t    vec_x,
    input  qvr_pkg::in_t    vec_y,
    input  qvr_pkg::in_t    vec_z,
    output logic            out_valid,
    input  logic            out_stall,
    output qvr_pkg::out_t   rot_x,
    output qvr_pkg::out_t   rot_y,
    output qvr_pkg::out_t   rot_z,
    output logic            zero_quat
);
    import qvr_pkg::*;

    localparam int DivSt = QuoW;
    localparam int NumSt = 4 + DivSt + 1;

    logic             adv;
    logic [NumSt-1:0] vld_reg;

    // Stage 1: products
    prod_t sq_reg [0:3];
    prod_t dot_reg [0:2];
    prod_t crs_reg [0:5];
    in_t   q1_reg [0:3];
    in_t   v1_reg [0:2];

    // Stage 2: norm and sums
    logic [NormW-1:0]        n2_reg;
    logic signed [NormW-1:0] s2_reg;
    logic signed [NormW:0]   uv2_reg;
    logic signed [NormW-1:0] c2_reg [0:2];
    in_t                     q2_reg [0:3];
    in_t                     v2_reg [0:2];

    // Stage 3: numerator terms
    num_t             ta_reg [0:2];
    num_t             tb_reg [0:2];
    num_t             tc_reg [0:2];
    logic [NormW-1:0] n3_reg;

    // Divide stages
    rem_t rem_reg [0:DivSt][0:2];
    quo_t quo_reg [0:DivSt][0:2];
    logic neg_reg [0:DivSt][0:2];
    dvs_t dvs_reg [0:DivSt];
    logic zq_reg  [0:DivSt];

    out_t rx_reg, ry_reg, rz_reg;
    logic zo_reg;

    num_t nsum [0:2];
    num_t nabs [0:2];
    logic signed [OutW:0] sres [0:2];
    out_t rres [0:2];

    assign adv      = !(vld_reg[NumSt-1] && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nsum[i] = ta_reg[i] + tb_reg[i] + tc_reg[i];
            nabs[i] = nsum[i][NumW-1] ? -nsum[i] : nsum[i];
            sres[i] = neg_reg[DivSt][i] ? -$signed({1'b0, quo_reg[DivSt][i]})
                                        : $signed({1'b0, quo_reg[DivSt][i]});
            if (sres[i] > $signed((OutW+1)'(65535)))
            begin
                rres[i] = out_t'(65535);
            end
            else if (sres[i] < $signed(-(OutW+1)'(65536)))
            begin
                rres[i] = out_t'(-65536);
            end
            else
            begin
                rres[i] = sres[i][OutW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NumSt-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0]  <= prod_t'(quat_x * quat_x);
            sq_reg[1]  <= prod_t'(quat_y * quat_y);
            sq_reg[2]  <= prod_t'(quat_z * quat_z);
            sq_reg[3]  <= prod_t'(quat_w * quat_w);
            dot_reg[0] <= prod_t'(quat_x * vec_x);
            dot_reg[1] <= prod_t'(quat_y * vec_y);
            dot_reg[2] <= prod_t'(quat_z * vec_z);
            crs_reg[0] <= prod_t'(quat_y * vec_z);
            crs_reg[1] <= prod_t'(quat_z * vec_y);
            crs_reg[2] <= prod_t'(quat_z * vec_x);
            crs_reg[3] <= prod_t'(quat_x * vec_z);
            crs_reg[4] <= prod_t'(quat_x * vec_y);
            crs_reg[5] <= prod_t'(quat_y * vec_x);
            q1_reg[0]  <= quat_x;
            q1_reg[1]  <= quat_y;
            q1_reg[2]  <= quat_z;
            q1_reg[3]  <= quat_w;
            v1_reg[0]  <= vec_x;
            v1_reg[1]  <= vec_y;
            v1_reg[2]  <= vec_z;

            n2_reg  <= NormW'(sq_reg[0]) + NormW'(sq_reg[1]) + NormW'(sq_reg[2])
                       + NormW'(sq_reg[3]);
            s2_reg  <= NormW'(sq_reg[3]) - NormW'(sq_reg[0]) - NormW'(sq_reg[1])
                       - NormW'(sq_reg[2]);
            uv2_reg <= ((NormW+1)'(dot_reg[0]) + (NormW+1)'(dot_reg[1])
                       + (NormW+1)'(dot_reg[2])) <<< 1;
            c2_reg[0] <= NormW'(crs_reg[0]) - NormW'(crs_reg[1]);
            c2_reg[1] <= NormW'(crs_reg[2]) - NormW'(crs_reg[3]);
            c2_reg[2] <= NormW'(crs_reg[4]) - NormW'(crs_reg[5]);
            q2_reg <= q1_reg;
            v2_reg <= v1_reg;

            for (int i = 0; i < 3; i++)
            begin
                ta_reg[i] <= num_t'(s2_reg * v2_reg[i]);
                tb_reg[i] <= num_t'(uv2_reg * q2_reg[i]);
                tc_reg[i] <= num_t'($signed({q2_reg[3], 1'b0}) * c2_reg[i]);
            end
            n3_reg <= n2_reg;

            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= rem_t'({nabs[i], 1'b0}) + rem_t'(n3_reg);
                quo_reg[0][i] <= '0;
                neg_reg[0][i] <= nsum[i][NumW-1];
            end
            dvs_reg[0] <= {n3_reg, 1'b0};
            zq_reg[0]  <= (n3_reg == '0);

            for (int k = 0; k < DivSt; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[k][i] >= (rem_t'(dvs_reg[k]) << (DivSt-1-k)))
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i]
                                           - (rem_t'(dvs_reg[k]) << (DivSt-1-k));
                        quo_reg[k+1][i] <= quo_reg[k][i]
                                           | (quo_t'(1) << (DivSt-1-k));
                    end
                    else
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i];
                        quo_reg[k+1][i] <= quo_reg[k][i];
                    end
                    neg_reg[k+1][i] <= neg_reg[k][i];
                end
                dvs_reg[k+1] <= dvs_reg[k];
                zq_reg[k+1]  <= zq_reg[k];
            end

            rx_reg <= zq_reg[DivSt] ? '0 : rres[0];
            ry_reg <= zq_reg[DivSt] ? '0 : rres[1];
            rz_reg <= zq_reg[DivSt] ? '0 : rres[2];
            zo_reg <= zq_reg[DivSt];
        end
    end

    assign out_valid = vld_reg[NumSt-1];
    assign rot_x     = rx_reg;
    assign rot_y     = ry_reg;
    assign rot_z     = rz_reg;
    assign zero_quat = zo_reg;

`ifndef SYNTHESIS
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_quat |-> rot_x == '0 && rot_y == '0 && rot_z == '0)
        else $error("zero quaternion beat carries a nonzero vector");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved while held");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NumSt-2] && !zq_reg[DivSt] |->
            rem_reg[DivSt][0] < rem_t'(dvs_reg[DivSt])
            && rem_reg[DivSt][1] < rem_t'(dvs_reg[DivSt])
            && rem_reg[DivSt][2] < rem_t'(dvs_reg[DivSt]))
        else $error("divide remainder not below divisor");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quaternion vector rotation pipeline.
// Directed beats cover the extremes, the zero quaternion and rounding
// ties. Random beats then run under three idling profiles on both
// sides. Every output beat is compared with an expectation computed here
// with exact integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;
    import qvr_pkg::*;

    typedef struct {
        out_t rx;
        out_t ry;
        out_t rz;
        logic zq;
    } rotation_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    in_t   quat_x, quat_y, quat_z, quat_w;
    in_t   vec_x, vec_y, vec_z;
    logic  out_valid;
    logic  out_stall;
    out_t  rot_x, rot_y, rot_z;
    logic  zero_quat;

    rotation_t rotations_due[$];
    int        mismatch_count;
    int        send_gap_pct;
    int        stall_pct;
    int        quiet_cycles;

    quaternion_vector_rotate dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic out_t clamp17(longint v);
        if (v > 65535)
            return 17'sd65535;
        if (v < -65536)
            return -17'sd65536;
        return out_t'(v);
    endfunction

    function automatic rotation_t rotate_vector(in_t qx, in_t qy, in_t qz, in_t qw,
                                                in_t vx, in_t vy, in_t vz);
        rotation_t r;
        longint    x, y, z, w, a, b, c;
        longint    uu, n, s, uv2, cx, cy, cz;
        x = qx; y = qy; z = qz; w = qw; a = vx; b = vy; c = vz;
        uu = x * x + y * y + z * z;
        n = w * w + uu;
        if (n == 0)
        begin
            r.rx = '0; r.ry = '0; r.rz = '0; r.zq = 1'b1;
            return r;
        end
        s = w * w - uu;
        uv2 = 2 * (x * a + y * b + z * c);
        cx = y * c - z * b;
        cy = z * a - x * c;
        cz = x * b - y * a;
        r.rx = clamp17(round_div(s * a + uv2 * x + 2 * w * cx, n));
        r.ry = clamp17(round_div(s * b + uv2 * y + 2 * w * cy, n));
        r.rz = clamp17(round_div(s * c + uv2 * z + 2 * w * cz, n));
        r.zq = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_beat(in_t qx, in_t qy, in_t qz, in_t qw,
                             in_t vx, in_t vy, in_t vz);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
        vec_x <= vx; vec_y <= vy; vec_z <= vz;
        rotations_due.push_back(rotate_vector(qx, qy, qz, qw, vx, vy, vz));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic in_t rand_comp();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return in_t'($urandom_range(8) - 4);
            default: return in_t'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rotations_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        rotation_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rotations_due.size() == 0)
            begin
                report_mismatch("unexpected output beat", 1, 0);
            end
            else
            begin
                e = rotations_due.pop_front();
                if (rot_x !== e.rx) report_mismatch("rot_x", rot_x, e.rx);
                if (rot_y !== e.ry) report_mismatch("rot_y", rot_y, e.ry);
                if (rot_z !== e.rz) report_mismatch("rot_z", rot_z, e.rz);
                if (zero_quat !== e.zq) report_mismatch("zero_quat", zero_quat, e.zq);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        send_beat(0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 5);
        send_beat(0, 0, 0, 0, 0, 0, 0);
        send_beat(0, 0, 0, 1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_beat(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_beat(16'sh7FFF, 0, 0, 0, 1, 2, 3);
        send_beat(0, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_beat(0, 0, 1, 1, 100, -100, 7);
        send_beat(1, 1, 1, 1, 16'sh8000, 16'sh8000, 16'sh8000);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 16'sh7FFF);
        send_beat(1, 0, 0, 1, 1, 1, 1);
        send_beat(1, 1, 0, 0, 3, -3, 1);
        send_beat(1, 1, 1, 0, 1, 0, 0);
        send_beat(2, 0, 0, 1, -1, 1, -1);
        send_beat(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_beat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z} = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();

        send_gap_pct = 12;
        stall_pct = 84;
        test_random(430);
        wait_drained();

        send_gap_pct = 84;
        stall_pct = 12;
        test_random(430);

        send_gap_pct = 0;
        stall_pct = 0;
        test_random(440);
        wait_drained();
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && rotations_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
